[hw/rtl/mm64_pkg.sv]
package mm64_pkg;

  // MurmurHash64A constants
  localparam logic [63:0] MixMul    = 64'hc6a4_a793_5bd1_e995;
  localparam int unsigned MixShift  = 47;
  localparam logic [63:0] SeedReset = 64'hdeca_fbad_deca_fbad;

  // Halves of the multiplier for the 32x32 partial products
  localparam logic [31:0] MulLo = MixMul[31:0];
  localparam logic [31:0] MulHi = MixMul[63:32];

  // Datapath operation: selects the multiplier operand and the writeback
  typedef enum logic [2:0] {
    OP_LEN,   // a = length,        h = seed ^ p
    OP_WORD,  // a = word,          k = p ^ (p >> 47)
    OP_K,     // a = k,             h = h ^ p
    OP_H,     // a = h,             h = p
    OP_PART,  // a = h ^ tail,      h = p
    OP_FIN    // a = h ^ (h >> 47), h = p ^ (p >> 47)
  } op_e;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic mul_req;
    op_e  op;
    logic load_out;
  } mm64_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mul_done;
    logic out_busy;
  } mm64_status_t;

endpackage

[hw/rtl/mm64_mul.sv]
module mm64_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  output logic        done_o,
  output logic [63:0] product_o
);
  import mm64_pkg::*;

  // Partial product sequence: low*low, high*low, low*high
  typedef enum logic [1:0] {
    STEP_LL,
    STEP_HL,
    STEP_LH
  } step_e;

  logic        busy_q, busy_d;
  step_e       step_q, step_d;
  logic [63:0] a_q, a_d;
  logic [63:0] res_q, res_d;
  logic [31:0] op_x, op_y;
  logic [63:0] pp;
  logic [63:0] res_next;

  // Operand selection for the shared 32x32 multiplier
  always_comb begin
    op_x = a_q[31:0];
    op_y = MulLo;
    unique case (step_q)
      STEP_LL: begin
        op_x = a_q[31:0];
        op_y = MulLo;
      end
      STEP_HL: begin
        op_x = a_q[63:32];
        op_y = MulLo;
      end
      STEP_LH: begin
        op_x = a_q[31:0];
        op_y = MulHi;
      end
      default: begin
        op_x = a_q[31:0];
        op_y = MulLo;
      end
    endcase
  end

  assign pp = 64'(op_x) * 64'(op_y);

  // Cross terms only reach the upper half of the truncated product
  always_comb begin
    if (step_q == STEP_LL) begin
      res_next = pp;
    end else begin
      res_next = res_q + {pp[31:0], 32'b0};
    end
  end

  assign done_o    = busy_q && (step_q == STEP_LH);
  assign product_o = res_next;

  // Step sequencing
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    a_d    = a_q;
    res_d  = res_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        step_d = STEP_LL;
        a_d    = a_i;
      end
    end else begin
      res_d = res_next;
      unique case (step_q)
        STEP_LL: step_d = STEP_HL;
        STEP_HL: step_d = STEP_LH;
        STEP_LH: begin
          step_d = STEP_LL;
          busy_d = 1'b0;
        end
        default: begin
          step_d = STEP_LL;
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= STEP_LL;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    res_q <= res_d;
  end

endmodule

[hw/rtl/mm64_datapath.sv]
module mm64_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mm64_pkg::mm64_cmd_t    cmd_i,
  output mm64_pkg::mm64_status_t status_o,
  input  logic                   hash_seed_we_i,
  input  logic [63:0]            hash_seed_i,
  input  logic [31:0]            message_length_i,
  input  logic [63:0]            data_word_i,
  input  logic [3:0]             byte_count_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [63:0]            hash_value_o
);
  import mm64_pkg::*;

  logic [63:0] seed_q;
  logic [63:0] h_q, h_d;
  logic [63:0] k_q, k_d;
  logic [31:0] len_q;
  logic [63:0] word_q;
  logic [3:0]  cnt_q;
  logic        out_valid_q;
  logic [63:0] hash_q;

  logic [63:0] tail;
  logic [63:0] mul_a;
  logic        mul_done;
  logic [63:0] prod;

  // Keep only the bytes below the count of a partial word
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      tail[8*i +: 8] = (4'(i) < cnt_q) ? word_q[8*i +: 8] : 8'h00;
    end
  end

  // Multiplier operand
  always_comb begin
    mul_a = h_q;
    unique case (cmd_i.op)
      OP_LEN:  mul_a = {32'b0, len_q};
      OP_WORD: mul_a = word_q;
      OP_K:    mul_a = k_q;
      OP_H:    mul_a = h_q;
      OP_PART: mul_a = h_q ^ tail;
      OP_FIN:  mul_a = h_q ^ (h_q >> MixShift);
      default: mul_a = h_q;
    endcase
  end

  mm64_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.mul_req),
    .a_i       (mul_a),
    .done_o    (mul_done),
    .product_o (prod)
  );

  // Writeback of the finished product
  always_comb begin
    h_d = h_q;
    k_d = k_q;
    if (mul_done) begin
      unique case (cmd_i.op)
        OP_LEN:  h_d = seed_q ^ prod;
        OP_WORD: k_d = prod ^ (prod >> MixShift);
        OP_K:    h_d = h_q ^ prod;
        OP_H:    h_d = prod;
        OP_PART: h_d = prod;
        OP_FIN:  h_d = prod ^ (prod >> MixShift);
        default: h_d = h_q;
      endcase
    end
  end

  // Seed register and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedReset;
      h_q    <= '0;
    end else begin
      if (hash_seed_we_i) begin
        seed_q <= hash_seed_i;
      end
      h_q <= h_d;
    end
  end

  // Input beat capture and mix word
  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    if (cmd_i.load_in) begin
      len_q  <= message_length_i;
      word_q <= data_word_i;
      cnt_q  <= byte_count_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      hash_q <= h_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign hash_value_o      = hash_q;
  assign status_o.mul_done = mul_done;
  assign status_o.out_busy = out_valid_q && out_stall_i;

endmodule

[hw/rtl/mm64_ctrl.sv]
module mm64_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   first_word_i,
  input  logic [3:0]             byte_count_i,
  input  logic                   last_word_i,
  output mm64_pkg::mm64_cmd_t    cmd_o,
  input  mm64_pkg::mm64_status_t status_i
);
  import mm64_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_WORD,
    S_K,
    S_H,
    S_PART,
    S_FIN,
    S_OUT
  } state_e;

  state_e state_q;
  logic   full_q;
  logic   part_q;
  logic   last_q;
  logic   in_msg_q;

  logic   acc_full;
  logic   acc_part;
  logic   acc_last;

  // Step that follows the seed load, or the acceptance of a later beat
  function automatic state_e mix_route(logic full, logic part, logic last);
    state_e nxt;
    if (full) begin
      nxt = S_WORD;
    end else if (part) begin
      nxt = S_PART;
    end else if (last) begin
      nxt = S_FIN;
    end else begin
      nxt = S_IDLE;
    end
    return nxt;
  endfunction

  // Decode of the accepted beat; counts above eight act as a full word
  assign acc_full = byte_count_i[3];
  assign acc_part = !byte_count_i[3] && (byte_count_i != 4'd0);
  assign acc_last = last_word_i || acc_part;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      full_q   <= 1'b0;
      part_q   <= 1'b0;
      last_q   <= 1'b0;
      in_msg_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            full_q <= acc_full;
            part_q <= acc_part;
            last_q <= acc_last;
            if (first_word_i) begin
              in_msg_q <= 1'b1;
              state_q  <= S_LEN;
            end else if (in_msg_q) begin
              state_q <= mix_route(acc_full, acc_part, acc_last);
            end
          end
        end
        S_LEN: begin
          if (status_i.mul_done) begin
            state_q <= mix_route(full_q, part_q, last_q);
          end
        end
        S_WORD: begin
          if (status_i.mul_done) begin
            state_q <= S_K;
          end
        end
        S_K: begin
          if (status_i.mul_done) begin
            state_q <= S_H;
          end
        end
        S_H: begin
          if (status_i.mul_done) begin
            state_q <= last_q ? S_FIN : S_IDLE;
          end
        end
        S_PART: begin
          if (status_i.mul_done) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (status_i.mul_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          // wait for the previous hash to leave the output register
          if (!status_i.out_busy) begin
            in_msg_q <= 1'b0;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Commands
  always_comb begin
    cmd_o.load_in  = 1'b0;
    cmd_o.mul_req  = 1'b0;
    cmd_o.op       = OP_H;
    cmd_o.load_out = 1'b0;
    unique case (state_q)
      S_IDLE: cmd_o.load_in = in_valid_i;
      S_LEN: begin
        cmd_o.mul_req = 1'b1;
        cmd_o.op      = OP_LEN;
      end
      S_WORD: begin
        cmd_o.mul_req = 1'b1;
        cmd_o.op      = OP_WORD;
      end
      S_K: begin
        cmd_o.mul_req = 1'b1;
        cmd_o.op      = OP_K;
      end
      S_H: begin
        cmd_o.mul_req = 1'b1;
        cmd_o.op      = OP_H;
      end
      S_PART: begin
        cmd_o.mul_req = 1'b1;
        cmd_o.op      = OP_PART;
      end
      S_FIN: begin
        cmd_o.mul_req = 1'b1;
        cmd_o.op      = OP_FIN;
      end
      S_OUT: cmd_o.load_out = !status_i.out_busy;
      default: cmd_o.load_in = 1'b0;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

[hw/rtl/murmur64a_stream_hasher_core.sv]
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-------------------------------------------
// input    | in_valid_i / in_stall_o   | first_word_i, message_length_i,
//          |                           | data_word_i, byte_count_i, last_word_i
// output   | out_valid_o / out_stall_i | hash_value_o
// config   | hash_seed_we_i            | hash_seed_i
//
// One beat is in work at a time. Every 64-bit multiply by the mix constant
// runs on a single shared 32x32 multiplier (three partial products).
// A full middle word takes three multiplies; a last beat adds the finalize
// multiply and the output load. A partial last beat takes its tail multiply,
// the finalize multiply and the output load, an empty last beat only the last
// two. Any first beat also adds the multiply for the seed load.
// Reset clears the sequencer and the output valid and loads the default seed.
// A stalled result holds in the output register; the next beat is still
// taken and only its own result waits for the register to free up.
module murmur64a_stream_hasher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        hash_seed_we_i,
  input  logic [63:0] hash_seed_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        first_word_i,
  input  logic [31:0] message_length_i,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o
);
  import mm64_pkg::*;

  mm64_cmd_t    cmd;
  mm64_status_t status;

  mm64_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .first_word_i (first_word_i),
    .byte_count_i (byte_count_i),
    .last_word_i  (last_word_i),
    .cmd_o        (cmd),
    .status_i     (status)
  );

  mm64_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .hash_seed_we_i   (hash_seed_we_i),
    .hash_seed_i      (hash_seed_i),
    .message_length_i (message_length_i),
    .data_word_i      (data_word_i),
    .byte_count_i     (byte_count_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hash_value_o     (hash_value_o)
  );

  // A multiply only completes while the sequencer is asking for one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.mul_done |-> cmd.mul_req)
    else $error("multiplier finished outside a multiply step");

  // A new hash never overwrites one that is still being held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(out_valid_o && out_stall_i))
    else $error("output register overwritten while stalled");

  // A first beat always starts work, so the input stalls next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && first_word_i) |=> in_stall_o)
    else $error("first beat accepted without starting the seed load");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import mm64_pkg::*;

  localparam int ResetCycles = 10;
  localparam int SettleCycles = 40;   // outlasts the longest beat in work
  localparam int IdleLimit = 2000;
  localparam int NumPhases = 6;
  localparam int PhaseBeats = 180;
  localparam int NumDirected = 24;

  // How a stimulus row is checked, or a seed load
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NO_HASH,
    ROW_FIXED_HASH,
    ROW_SEED
  } row_kind_e;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_CHOPPY,
    STALL_LONG
  } stall_mode_e;

  typedef struct packed {
    logic        first;
    logic [31:0] len;
    logic [63:0] word;
    logic [3:0]  cnt;
    logic        last;
  } beat_t;

  typedef struct packed {
    row_kind_e   kind;
    beat_t       beat;
    logic [63:0] value;  // fixed hash or seed
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        seed_we;
  logic [63:0] seed_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        first_word;
  logic [31:0] message_length;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last_word;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] hash_value;

  // Hash model state
  logic [63:0] seed_q;
  logic [63:0] acc_q;
  logic        open_q;

  logic [63:0] hashes_q[$];
  logic [63:0] want_hash;
  row_t        dir_rows [NumDirected];

  int errors = 0;
  int beats_taken = 0;
  int beats_ignored = 0;
  int restarts = 0;
  int hashes_seen = 0;
  int seed_loads = 0;
  int burst_left = 0;

  murmur64a_stream_hasher_core i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .hash_seed_we_i   (seed_we),
    .hash_seed_i      (seed_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .first_word_i     (first_word),
    .message_length_i (message_length),
    .data_word_i      (data_word),
    .byte_count_i     (byte_count),
    .last_word_i      (last_word),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .hash_value_o     (hash_value)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the hash model by one accepted beat
  task automatic hash_step(input beat_t b, output logic emit, output logic [63:0] hv,
                           output logic skipped);
    logic [63:0] h;
    logic [63:0] k;
    emit = 1'b0;
    hv = '0;
    skipped = 1'b0;
    if (b.first) begin
      if (open_q) restarts++;
      acc_q = seed_q ^ (64'(b.len) * MixMul);
      open_q = 1'b1;
    end
    if (!open_q) begin
      skipped = 1'b1;
    end else begin
      h = acc_q;
      if (b.cnt >= 4'd8) begin
        k = b.word * MixMul;
        k ^= k >> MixShift;
        k *= MixMul;
        h = (h ^ k) * MixMul;
      end else if (b.cnt != 4'd0) begin
        // tail bytes only, upper bytes dropped
        h = (h ^ (b.word & ((64'd1 << {b.cnt, 3'b000}) - 64'd1))) * MixMul;
      end
      acc_q = h;
      // a partial word always closes the message
      if (b.last || (b.cnt != 4'd0 && b.cnt < 4'd8)) begin
        h ^= h >> MixShift;
        h *= MixMul;
        h ^= h >> MixShift;
        emit = 1'b1;
        hv = h;
        open_q = 1'b0;
      end
    end
  endtask

  // Drive one beat in bursts with random gaps, then log its hash
  task automatic send_beat(input beat_t b, input row_kind_e kind, input logic [63:0] fixed);
    logic        emit;
    logic [63:0] hv;
    logic        skipped;
    int          gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    first_word     <= b.first;
    message_length <= b.len;
    data_word      <= b.word;
    byte_count     <= b.cnt;
    last_word      <= b.last;
    do @(posedge clk); while (in_stall !== 1'b0);
    hash_step(b, emit, hv, skipped);
    case (kind)
      ROW_NO_HASH: begin
        emit = 1'b0;
      end
      ROW_FIXED_HASH: begin
        emit = 1'b1;
        hv = fixed;
      end
      default: ;
    endcase
    if (emit) hashes_q.push_back(hv);
    if (skipped) beats_ignored++;
    else beats_taken++;
  endtask

  // Seed write once the block has drained
  task automatic load_seed(input logic [63:0] val);
    in_valid <= 1'b0;
    burst_left = 0;
    while (hashes_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    seed_we    <= 1'b1;
    seed_wdata <= val;
    @(posedge clk);
    seed_we <= 1'b0;
    seed_q = val;
    seed_loads++;
  endtask

  // One random message, sometimes preceded by stray beats or cut short
  task automatic gen_message();
    int          nbytes;
    int          nwords;
    int          tail;
    int          total;
    int          cut;
    logic [31:0] len;
    logic        late_close;
    beat_t       b;
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        b.first = 1'b0;
        b.len   = $urandom;
        b.word  = {$urandom, $urandom};
        b.cnt   = 4'($urandom_range(0, 15));
        b.last  = 1'($urandom_range(0, 1));
        send_beat(b, ROW_PREDICT, '0);
      end
    end
    case ($urandom_range(0, 19))
      0: nbytes = $urandom_range(41, 200);
      1, 2: nbytes = $urandom_range(0, 8);
      default: nbytes = $urandom_range(0, 40);
    endcase
    len = ($urandom_range(0, 7) == 0) ? $urandom : nbytes;
    nwords = nbytes / 8;
    tail = nbytes % 8;
    // whole-word message closed by a trailing empty beat
    late_close = (tail == 0 && nwords != 0 && $urandom_range(0, 9) == 0);
    total = (nbytes == 0) ? 1 : nwords + (tail != 0) + late_close;
    cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, total) : total;
    for (int i = 0; i < cut; i++) begin
      if (i != 0 && $urandom_range(0, 24) == 0) begin
        // empty non-last beat: no effect on the hash
        b.first = 1'b0;
        b.len   = $urandom;
        b.word  = {$urandom, $urandom};
        b.cnt   = 4'd0;
        b.last  = 1'b0;
        send_beat(b, ROW_PREDICT, '0);
      end
      b.first = (i == 0);
      b.len   = (i == 0) ? len : $urandom;
      b.word  = {$urandom, $urandom};
      if (nbytes == 0 || i == nwords + (tail != 0)) begin
        b.cnt  = 4'd0;
        b.last = 1'b1;
      end else if (i < nwords) begin
        b.cnt  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
        b.last = (i == nwords - 1) && tail == 0 && !late_close;
      end else begin
        b.cnt  = 4'(tail);
        b.last = 1'($urandom_range(0, 1));
      end
      send_beat(b, ROW_PREDICT, '0);
    end
  endtask

  // Output stall pattern, switching among none, choppy and long stalls
  stall_mode_e stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          run_left = 0;
  logic        stall_on = 1'b0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      mode_left = $urandom_range(100, 600);
    end
    mode_left--;
    if (run_left == 0) begin
      stall_on = !stall_on;
      case (stall_mode)
        STALL_NONE: begin
          stall_on = 1'b0;
          run_left = 20;
        end
        STALL_CHOPPY: run_left = $urandom_range(1, 3);
        default: run_left = stall_on ? $urandom_range(5, 30) : $urandom_range(1, 6);
      endcase
    end
    run_left--;
    out_stall <= stall_on;
  end

  // Hash checker
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (hashes_q.size() == 0) begin
        $display("%0t: unexpected hash, expected none, got %h", $time, hash_value);
        errors++;
      end else begin
        want_hash = hashes_q.pop_front();
        hashes_seen++;
        if (hash_value !== want_hash) begin
          $display("%0t: hash mismatch, expected %h, got %h", $time, want_hash, hash_value);
          errors++;
        end
      end
    end
  end

  // Watchdog on stalled traffic
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || seed_we) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: nothing accepted for %0d cycles", $time, IdleLimit);
    $display("== FAIL ==");
    $finish;
  end

  // Main sequence
  initial begin
    int target;
    dir_rows = '{
      '{ROW_PREDICT,    '{1'b1, 32'd0,  64'h0,                  4'd0,  1'b1}, 64'h0},
      '{ROW_NO_HASH,    '{1'b0, 32'd8,  64'hffff_ffff_ffff_ffff, 4'd8,  1'b1}, 64'h0},
      '{ROW_PREDICT,    '{1'b1, 32'd8,  64'hffff_ffff_ffff_ffff, 4'd8,  1'b1}, 64'h0},
      '{ROW_PREDICT,    '{1'b1, 32'd3,  64'h0123_4567_89ab_cdef, 4'd3,  1'b0}, 64'h0},
      '{ROW_SEED,       '{1'b0, 32'd0,  64'h0,                  4'd0,  1'b0}, 64'h0},
      '{ROW_FIXED_HASH, '{1'b1, 32'd0,  64'hffff_ffff_ffff_ffff, 4'd0,  1'b1}, 64'h0},
      '{ROW_PREDICT,    '{1'b1, 32'hffff_ffff, 64'h0,           4'd8,  1'b0}, 64'h0},
      '{ROW_PREDICT,    '{1'b0, 32'd0,  64'hffff_ffff_ffff_ffff, 4'd15, 1'b0}, 64'h0},
      '{ROW_PREDICT,    '{1'b0, 32'd0,  64'hffff_ffff_ffff_ffff, 4'd0,  1'b0}, 64'h0},
      '{ROW_PREDICT,    '{1'b0, 32'd0,  64'hffff_ffff_ffff_ffff, 4'd3,  1'b0}, 64'h0},
      '{ROW_NO_HASH,    '{1'b0, 32'd8,  64'ha5a5_a5a5_a5a5_a5a5, 4'd8,  1'b1}, 64'h0},
      '{ROW_PREDICT,    '{1'b1, 32'd16, 64'h5a5a_5a5a_5a5a_5a5a, 4'd8,  1'b0}, 64'h0},
      '{ROW_PREDICT,    '{1'b1, 32'd5,  64'hffff_ffff_ffff_ffff, 4'd5,  1'b1}, 64'h0},
      '{ROW_PREDICT,    '{1'b1, 32'd8,  64'h0123_4567_89ab_cdef, 4'd8,  1'b0}, 64'h0},
      '{ROW_PREDICT,    '{1'b0, 32'd8,  64'h0,                  4'd0,  1'b1}, 64'h0},
      '{ROW_PREDICT,    '{1'b1, 32'd1,  64'hffff_ffff_ffff_ffff, 4'd1,  1'b1}, 64'h0},
      '{ROW_PREDICT,    '{1'b1, 32'd7,  64'hffff_ffff_ffff_ffff, 4'd7,  1'b1}, 64'h0},
      '{ROW_SEED,       '{1'b0, 32'd0,  64'h0,                  4'd0,  1'b0},
        64'hffff_ffff_ffff_ffff},
      '{ROW_PREDICT,    '{1'b1, 32'd24, 64'hfedc_ba98_7654_3210, 4'd8,  1'b0}, 64'h0},
      '{ROW_PREDICT,    '{1'b0, 32'd24, 64'h8000_0000_0000_0001, 4'd9,  1'b0}, 64'h0},
      '{ROW_PREDICT,    '{1'b0, 32'd24, 64'h7fff_ffff_ffff_fffe, 4'd8,  1'b1}, 64'h0},
      '{ROW_PREDICT,    '{1'b1, 32'd2,  64'hffff_ffff_ffff_ffff, 4'd0,  1'b0}, 64'h0},
      '{ROW_PREDICT,    '{1'b0, 32'd2,  64'hffff_ffff_ffff_ffff, 4'd2,  1'b1}, 64'h0},
      '{ROW_NO_HASH,    '{1'b0, 32'd0,  64'h0,                  4'd8,  1'b0}, 64'h0}
    };
    seed_q = SeedReset;
    acc_q = '0;
    open_q = 1'b0;
    rst_n          <= 1'b0;
    seed_we        <= 1'b0;
    seed_wdata     <= '0;
    in_valid       <= 1'b0;
    first_word     <= 1'b0;
    message_length <= '0;
    data_word      <= '0;
    byte_count     <= '0;
    last_word      <= 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, default seed first
    for (int r = 0; r < NumDirected; r++) begin
      if (dir_rows[r].kind == ROW_SEED) load_seed(dir_rows[r].value);
      else send_beat(dir_rows[r].beat, dir_rows[r].kind, dir_rows[r].value);
    end

    // random messages over several seeds
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        1: load_seed(64'hffff_ffff_ffff_ffff);
        2: load_seed(64'h0);
        3: load_seed(SeedReset);
        default: load_seed({$urandom, $urandom});
      endcase
      target = beats_taken + PhaseBeats;
      while (beats_taken < target) gen_message();
    end

    in_valid <= 1'b0;
    while (hashes_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Covered %0d message beats plus %0d ignored, %0d restarts, %0d hashes checked,",
             beats_taken, beats_ignored, restarts, hashes_seen);
    $display("over %0d seed loads with bursty input and a varying output stall.", seed_loads);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d errors", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
